/* design/pixel_integer_upscaler_top_assert.svh */
// Assertion macros shared by the upscaler RTL.
`ifndef PIXEL_INTEGER_UPSCALER_TOP_ASSERT_SVH
`define PIXEL_INTEGER_UPSCALER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIU_ASSERT_NOW(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("upscaler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PIU_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("upscaler assertion failed");

`endif

/* design/piu_pkg.sv */
// Package with the constants and codes of the pixel integer upscaler.
`timescale 1ns / 1ps
package piu_pkg;

	// Default sizes of the line store and of the replication factor.
	localparam int DEFAULT_MAX_WIDTH = 2048;
	localparam int DEFAULT_MAX_SCALE = 16;

	// Field widths of the register file and the pixel.
	localparam int SCALE_W     = 5;
	localparam int ROW_WIDTH_W = 12;
	localparam int COLOUR_W    = 8;
	localparam int PIXEL_W     = 3 * COLOUR_W;
	localparam int PAD_W       = 2;
	localparam int PDATA_W     = 32;
	localparam int PADDR_W     = 3;
	localparam int REG_IDX_W   = 1;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_SCALE = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH = 1'b1;

	// Register reset values.
	localparam logic [SCALE_W-1:0]     SCALE_RESET = 5'd1;
	localparam logic [ROW_WIDTH_W-1:0] WIDTH_RESET = 12'd1;

	// Request type codes.
	localparam logic REQ_PIXEL   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

endpackage

/* design/pixel_integer_upscaler_top.sv */
// Nearest-neighbour integer upscaler for 24-bit pixels, with line store and APB registers.
`timescale 1ns / 1ps
// Each accepted pixel is written to the line store and sent out scale_factor times; after
// the last pixel of an input row, scale_factor-1 replay rows are owed, and each advance
// transaction reads the next stored pixel and sends it out scale_factor times. The copy
// that ends an output row carries row_end and the number of pad bytes that bring the row
// to a 4-byte boundary; last marks the final copy of each input transaction. Copies pass
// from the copy stage through the output register, one per cycle while the consumer does
// not stall the output. An item occupies the copy stage until its last copy (scale_factor
// is 1 to MAX_SCALE) moves to the output register, and no new item is taken before then;
// the next item is taken in the cycle its predecessor's last copy moves to the output
// register. Items that give no result (scale zero, a pixel while a replay is owed, an
// advance with nothing owed) are accepted and dropped without entering the copy stage. The
// line store is a single-port-write, single-port-read memory with a registered read.
module pixel_integer_upscaler_top #(
	parameter int MAX_WIDTH = piu_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_SCALE = piu_pkg::DEFAULT_MAX_SCALE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [piu_pkg::PADDR_W-1:0]       paddr,
	input  logic [piu_pkg::PDATA_W-1:0]       pwdata,
	output logic [piu_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [piu_pkg::COLOUR_W-1:0]      blue,
	input  logic [piu_pkg::COLOUR_W-1:0]      green,
	input  logic [piu_pkg::COLOUR_W-1:0]      red,
	// Output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [piu_pkg::COLOUR_W-1:0]      out_blue,
	output logic [piu_pkg::COLOUR_W-1:0]      out_green,
	output logic [piu_pkg::COLOUR_W-1:0]      out_red,
	output logic [piu_pkg::PAD_W-1:0]         pad_count,
	output logic                              row_end,
	output logic                              last
);
	import piu_pkg::*;

	// Column index, effective width, effective scale and owed-row counter widths.
	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW  = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_W) ?
		$clog2(MAX_WIDTH + 1) : ROW_WIDTH_W;
	localparam int SW  = ($clog2(MAX_SCALE + 1) > SCALE_W) ? $clog2(MAX_SCALE + 1) : SCALE_W;
	localparam int OW  = $clog2(MAX_SCALE);

	// Configuration registers.
	logic [SCALE_W-1:0]     scale_q;
	logic [ROW_WIDTH_W-1:0] row_width_q;

	// Control state.
	logic [CW-1:0] fill_column_q;
	logic [CW-1:0] replay_column_q;
	logic [OW-1:0] rows_owed_q;

	// Line store and its registered read data.
	logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];
	logic [PIXEL_W-1:0] rd_data_q;

	// Copy stage.
	logic               valid_s1;
	logic               is_adv_s1;
	logic [PIXEL_W-1:0] pix_s1;
	logic               at_end_s1;
	logic [SW-1:0]      scale_s1;
	logic [PAD_W-1:0]   pad_s1;
	logic [OW-1:0]      copy_cnt_q;

	// Output register.
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_pix_q;
	logic [PAD_W-1:0]   out_pad_q;
	logic               out_row_end_q;
	logic               out_last_q;

	// Combinational signals.
	logic                 cfg_write;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [EW-1:0]        row_width_ext;
	logic [EW-1:0]        eff_width;
	logic [SW-1:0]        scale_ext;
	logic [SW-1:0]        eff_scale;
	logic [PAD_W-1:0]     pad_now;
	logic                 in_accept;
	logic                 take_pixel;
	logic                 take_advance;
	logic [CW-1:0]        cur_column;
	logic                 cur_at_end;
	logic                 emit;
	logic                 final_copy;
	logic [PIXEL_W-1:0]   copy_pix;

	// APB register access; writes complete in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_index = paddr[PADDR_W-1:2];

	always_comb begin
		case (cfg_index)
			REG_SCALE: prdata = PDATA_W'(scale_q);
			REG_WIDTH: prdata = PDATA_W'(row_width_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RESET;
			row_width_q <= WIDTH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SCALE: scale_q     <= pwdata[SCALE_W-1:0];
				REG_WIDTH: row_width_q <= pwdata[ROW_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective width and scale, clamped to what the store and counters hold.
	assign row_width_ext = EW'(row_width_q);
	assign scale_ext     = SW'(scale_q);

	always_comb begin
		if (row_width_q == '0) begin
			eff_width = EW'(1);
		end else if (row_width_ext > EW'(MAX_WIDTH)) begin
			eff_width = EW'(MAX_WIDTH);
		end else begin
			eff_width = row_width_ext;
		end
		if (scale_ext > SW'(MAX_SCALE)) begin
			eff_scale = SW'(MAX_SCALE);
		end else begin
			eff_scale = scale_ext;
		end
	end

	// Pad bytes are the negated 3*width*scale modulo four, which is width*scale modulo four.
	assign pad_now = eff_width[1:0] * eff_scale[1:0];

	// Input acceptance and classification of the transaction.
	assign in_ready     = !valid_s1 || (emit && final_copy);
	assign in_accept    = in_valid && in_ready;
	assign take_pixel   = in_accept && (eff_scale != '0) && (req_type == REQ_PIXEL) &&
		(rows_owed_q == '0);
	assign take_advance = in_accept && (eff_scale != '0) && (req_type == REQ_ADVANCE) &&
		(rows_owed_q != '0);
	assign cur_column   = (req_type == REQ_PIXEL) ? fill_column_q : replay_column_q;
	assign cur_at_end   = (EW'(cur_column) + EW'(1)) >= eff_width;

	// Column pointers and owed rows advance when a transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_column_q   <= '0;
			replay_column_q <= '0;
			rows_owed_q     <= '0;
		end else begin
			if (take_pixel) begin
				if (cur_at_end) begin
					fill_column_q <= '0;
					rows_owed_q   <= OW'(eff_scale - SW'(1));
				end else begin
					fill_column_q <= cur_column + CW'(1);
				end
			end
			if (take_advance) begin
				if (cur_at_end) begin
					replay_column_q <= '0;
					rows_owed_q     <= rows_owed_q - OW'(1);
				end else begin
					replay_column_q <= cur_column + CW'(1);
				end
			end
		end
	end

	// Line store: pixels are written, replay advances read the stored column.
	always_ff @(posedge clk) begin
		if (take_pixel) begin
			line_mem[cur_column] <= {red, green, blue};
		end
		if (take_advance) begin
			rd_data_q <= line_mem[cur_column];
		end
	end

	// Copy stage holds one item while its copies are sent.
	assign emit       = valid_s1 && (!out_valid_q || out_ready);
	assign final_copy = (SW'(copy_cnt_q) + SW'(1)) == scale_s1;
	assign copy_pix   = is_adv_s1 ? rd_data_q : pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			copy_cnt_q <= '0;
		end else begin
			if (take_pixel || take_advance) begin
				valid_s1 <= 1'b1;
			end else if (emit && final_copy) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				copy_cnt_q <= final_copy ? '0 : copy_cnt_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_pixel || take_advance) begin
			is_adv_s1 <= take_advance;
			pix_s1    <= {red, green, blue};
			at_end_s1 <= cur_at_end;
			scale_s1  <= eff_scale;
			pad_s1    <= pad_now;
		end
	end

	// Output register parts the copy stage from the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pix_q     <= copy_pix;
			out_last_q    <= final_copy;
			out_row_end_q <= final_copy && at_end_s1;
			out_pad_q     <= (final_copy && at_end_s1) ? pad_s1 : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_blue  = out_pix_q[COLOUR_W-1:0];
	assign out_green = out_pix_q[2*COLOUR_W-1:COLOUR_W];
	assign out_red   = out_pix_q[3*COLOUR_W-1:2*COLOUR_W];
	assign pad_count = out_pad_q;
	assign row_end   = out_row_end_q;
	assign last      = out_last_q;

	// Checks on the control state, the copy stage and the output register.
	`include "pixel_integer_upscaler_top_assert.svh"

	`PIU_ASSERT_NOW(a_owed_at_row_start, clk, arst_n, rows_owed_q != '0, fill_column_q == '0)
	`PIU_ASSERT_NOW(a_copy_in_range, clk, arst_n, valid_s1, SW'(copy_cnt_q) < scale_s1)
	`PIU_ASSERT_NEXT(a_idle_advance_dropped, clk, arst_n,
		in_accept && (req_type == REQ_ADVANCE) && (rows_owed_q == '0), !valid_s1)
	`PIU_ASSERT_NOW(a_pad_only_at_row_end, clk, arst_n, out_valid_q && (out_pad_q != '0),
		out_row_end_q && out_last_q)

endmodule
